// ===== src/bfdm_pkg.sv =====
// ----------------------------------------------------------------------------
// bfdm_pkg
// Shared widths, reset values, register indexes and beat payload types of the
// block frame difference motion detector.
// ----------------------------------------------------------------------------
package bfdm_pkg;

   localparam int SAMPLE_W           = 8;
   localparam int THRESHOLD_W        = 8;
   localparam int PERCENT_W          = 7;
   localparam int FRAME_BLOCKS_W     = 14;
   localparam int COUNT_W            = 14;
   localparam int CSR_INDEX_W        = 2;
   localparam int CSR_DATA_W         = 14;
   localparam int MAX_BLOCKS_DEFAULT = 8192;

   localparam logic [THRESHOLD_W-1:0]    THRESHOLD_RESET    = 8'd10;
   localparam logic [PERCENT_W-1:0]      PERCENT_RESET      = 7'd20;
   localparam logic [FRAME_BLOCKS_W-1:0] FRAME_BLOCKS_RESET = 14'd8192;
   localparam logic [PERCENT_W-1:0]      PERCENT_SCALE      = 7'd100;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHANGE_THRESHOLD = 2'd0,
      CSR_MOTION_PERCENT   = 2'd1,
      CSR_FRAME_BLOCKS     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                frame_end;
   } req_payload_type;

   typedef struct packed {
      logic               motion;
      logic [COUNT_W-1:0] change_count;
      logic [COUNT_W-1:0] block_count;
   } rsp_payload_type;

endpackage

// ===== src/bfdm_stream_if.sv =====
// ----------------------------------------------------------------------------
// bfdm_stream_if
// Valid/ready stream channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface bfdm_stream_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ===== src/bfdm_ram.sv =====
// ----------------------------------------------------------------------------
// bfdm_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is enabled.
// ----------------------------------------------------------------------------
module bfdm_ram
   import bfdm_pkg::*;
#(
   parameter int WIDTH = SAMPLE_W,
   parameter int DEPTH = MAX_BLOCKS_DEFAULT,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              write_enable,
   input  logic [ADDR_W-1:0] write_addr,
   input  logic [WIDTH-1:0]  write_data,
   input  logic              read_enable,
   input  logic [ADDR_W-1:0] read_addr,
   output logic [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== src/block_frame_difference_motion.sv =====
// ----------------------------------------------------------------------------
// block_frame_difference_motion
// Frame difference motion detector on one luma sample per 8x8 block.
// ----------------------------------------------------------------------------
// One block sample beat is taken every cycle unless the result output stalls
// the pipeline. Each sample is compared with the sample stored for the same
// block in the previous frame; differences above change_threshold count as
// changes and the new sample replaces the stored one. Samples past frame_blocks
// (capped at MAX_BLOCKS) are ignored but their frame end mark still closes the
// frame. On the last-of-frame beat one result beat carries the counts and the
// motion flag (changes*100 > percent*blocks). The sample store is a single RAM
// with one read and one write each cycle; recent writes are forwarded and a
// fill mark makes never-written entries read as zero, so the store needs no
// clearing pass after reset and the block is ready at once. The user must
// write configuration only while the block is idle, which is not enforced.
// ----------------------------------------------------------------------------
module block_frame_difference_motion
   import bfdm_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   bfdm_stream_if.sink            req_if,
   bfdm_stream_if.source          rsp_if,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int ADDR_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int CMP_W  = (CNT_W > FRAME_BLOCKS_W) ? CNT_W : FRAME_BLOCKS_W;
   localparam int PROD_W = CNT_W + PERCENT_W;
   localparam logic [CMP_W-1:0] MAX_LIMIT = CMP_W'(MAX_BLOCKS);

   // configuration
   logic [THRESHOLD_W-1:0]    threshold_ff, threshold_in;
   logic [PERCENT_W-1:0]      percent_ff, percent_in;
   logic [FRAME_BLOCKS_W-1:0] frame_blocks_ff, frame_blocks_in;

   // frame position and store fill mark
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] changed_ff, changed_in;

   // read stage
   logic                s1_valid_ff, s1_valid_in;
   logic [SAMPLE_W-1:0] s1_sample_ff, s1_sample_in;
   logic                s1_frame_end_ff, s1_frame_end_in;
   logic                s1_in_range_ff, s1_in_range_in;
   logic [ADDR_W-1:0]   s1_addr_ff, s1_addr_in;
   logic [CNT_W-1:0]    s1_blocks_ff, s1_blocks_in;
   logic                s1_unwritten_ff, s1_unwritten_in;
   logic                s1_bypass_ff, s1_bypass_in;
   logic [SAMPLE_W-1:0] s1_bypass_data_ff, s1_bypass_data_in;

   // compare stage
   logic                s2_valid_ff, s2_valid_in;
   logic [SAMPLE_W-1:0] s2_sample_ff, s2_sample_in;
   logic [SAMPLE_W-1:0] s2_old_ff, s2_old_in;
   logic                s2_frame_end_ff, s2_frame_end_in;
   logic                s2_in_range_ff, s2_in_range_in;
   logic [ADDR_W-1:0]   s2_addr_ff, s2_addr_in;
   logic [CNT_W-1:0]    s2_blocks_ff, s2_blocks_in;

   // frame total stage
   logic             s3_valid_ff, s3_valid_in;
   logic [CNT_W-1:0] s3_changed_ff, s3_changed_in;
   logic [CNT_W-1:0] s3_blocks_ff, s3_blocks_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic                out_free, s3_adv, s3_free, s2_adv, s2_free, s1_adv, s1_free;
   logic                accept, in_range, ram_we, ram_re;
   logic [CMP_W-1:0]    limit, frame_blocks_ext;
   logic [SAMPLE_W-1:0] ram_rdata, diff;
   logic                hit;
   logic [CNT_W-1:0]    changed_next;
   logic [PROD_W-1:0]   lhs, rhs;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign s3_adv   = s3_valid_ff && out_free;
   assign s3_free  = !s3_valid_ff || out_free;
   assign s2_adv   = s2_valid_ff && (!s2_frame_end_ff || s3_free);
   assign s2_free  = !s2_valid_ff || s2_adv;
   assign s1_adv   = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || s1_adv;

   assign req_if.ready = s1_free;
   assign accept       = req_if.valid && s1_free;

   assign frame_blocks_ext = CMP_W'(frame_blocks_ff);
   assign limit            = (frame_blocks_ext > MAX_LIMIT) ? MAX_LIMIT : frame_blocks_ext;
   assign in_range         = CMP_W'(pos_ff) < limit;

   assign ram_re = accept && in_range;
   assign ram_we = s2_adv && s2_in_range_ff;

   bfdm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_BLOCKS)
   ) u_sample_store (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (s2_addr_ff),
      .write_data   (s2_sample_ff),
      .read_enable  (ram_re),
      .read_addr    (pos_ff[ADDR_W-1:0]),
      .read_data    (ram_rdata)
   );

   assign diff = (s2_sample_ff > s2_old_ff) ? (s2_sample_ff - s2_old_ff)
                                            : (s2_old_ff - s2_sample_ff);
   assign hit          = s2_in_range_ff && (diff > threshold_ff);
   assign changed_next = changed_ff + CNT_W'(hit);

   assign lhs = PROD_W'(s3_changed_ff) * PROD_W'(PERCENT_SCALE);
   assign rhs = PROD_W'(percent_ff) * PROD_W'(s3_blocks_ff);

   always_comb begin
      threshold_in    = threshold_ff;
      percent_in      = percent_ff;
      frame_blocks_in = frame_blocks_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CHANGE_THRESHOLD: begin
               threshold_in = csr_write_data[THRESHOLD_W-1:0];
            end
            CSR_MOTION_PERCENT: begin
               percent_in = csr_write_data[PERCENT_W-1:0];
            end
            CSR_FRAME_BLOCKS: begin
               frame_blocks_in = csr_write_data[FRAME_BLOCKS_W-1:0];
            end
            default: begin
            end
         endcase
      end

      // position of the next sample in the frame
      pos_in = pos_ff;
      if (accept) begin
         if (req_if.payload.frame_end) begin
            pos_in = '0;
         end else if (in_range) begin
            pos_in = pos_ff + 1'b1;
         end
      end

      // stored entries are always a prefix of the store
      fill_in = fill_ff;
      if (ram_we && (CNT_W'(s2_addr_ff) == fill_ff)) begin
         fill_in = fill_ff + 1'b1;
      end

      s1_valid_in       = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s1_sample_in      = s1_sample_ff;
      s1_frame_end_in   = s1_frame_end_ff;
      s1_in_range_in    = s1_in_range_ff;
      s1_addr_in        = s1_addr_ff;
      s1_blocks_in      = s1_blocks_ff;
      s1_unwritten_in   = s1_unwritten_ff;
      s1_bypass_in      = s1_bypass_ff;
      s1_bypass_data_in = s1_bypass_data_ff;
      if (accept) begin
         s1_sample_in      = req_if.payload.sample;
         s1_frame_end_in   = req_if.payload.frame_end;
         s1_in_range_in    = in_range;
         s1_addr_in        = pos_ff[ADDR_W-1:0];
         s1_blocks_in      = in_range ? (pos_ff + 1'b1) : pos_ff;
         s1_unwritten_in   = pos_ff >= fill_ff;
         // write landing in the same cycle as the read
         s1_bypass_in      = ram_we && (s2_addr_ff == pos_ff[ADDR_W-1:0]);
         s1_bypass_data_in = s2_sample_ff;
      end

      s2_valid_in     = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_ff);
      s2_sample_in    = s2_sample_ff;
      s2_old_in       = s2_old_ff;
      s2_frame_end_in = s2_frame_end_ff;
      s2_in_range_in  = s2_in_range_ff;
      s2_addr_in      = s2_addr_ff;
      s2_blocks_in    = s2_blocks_ff;
      if (s1_adv) begin
         s2_sample_in    = s1_sample_ff;
         s2_frame_end_in = s1_frame_end_ff;
         s2_in_range_in  = s1_in_range_ff;
         s2_addr_in      = s1_addr_ff;
         s2_blocks_in    = s1_blocks_ff;
         if (ram_we && (s2_addr_ff == s1_addr_ff)) begin
            s2_old_in = s2_sample_ff;
         end else if (s1_bypass_ff) begin
            s2_old_in = s1_bypass_data_ff;
         end else if (s1_unwritten_ff) begin
            s2_old_in = '0;
         end else begin
            s2_old_in = ram_rdata;
         end
      end

      changed_in = changed_ff;
      if (s2_adv) begin
         changed_in = s2_frame_end_ff ? '0 : changed_next;
      end

      s3_valid_in   = (s2_adv && s2_frame_end_ff) ? 1'b1 : (s3_adv ? 1'b0 : s3_valid_ff);
      s3_changed_in = s3_changed_ff;
      s3_blocks_in  = s3_blocks_ff;
      if (s2_adv && s2_frame_end_ff) begin
         s3_changed_in = changed_next;
         s3_blocks_in  = s2_blocks_ff;
      end

      rsp_valid_in   = s3_adv ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
      rsp_payload_in = rsp_payload_ff;
      if (s3_adv) begin
         rsp_payload_in.motion       = lhs > rhs;
         rsp_payload_in.change_count = COUNT_W'(s3_changed_ff);
         rsp_payload_in.block_count  = COUNT_W'(s3_blocks_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= THRESHOLD_RESET;
         percent_ff      <= PERCENT_RESET;
         frame_blocks_ff <= FRAME_BLOCKS_RESET;
         pos_ff          <= '0;
         fill_ff         <= '0;
         changed_ff      <= '0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         threshold_ff    <= threshold_in;
         percent_ff      <= percent_in;
         frame_blocks_ff <= frame_blocks_in;
         pos_ff          <= pos_in;
         fill_ff         <= fill_in;
         changed_ff      <= changed_in;
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
         s3_valid_ff     <= s3_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sample_ff      <= s1_sample_in;
      s1_frame_end_ff   <= s1_frame_end_in;
      s1_in_range_ff    <= s1_in_range_in;
      s1_addr_ff        <= s1_addr_in;
      s1_blocks_ff      <= s1_blocks_in;
      s1_unwritten_ff   <= s1_unwritten_in;
      s1_bypass_ff      <= s1_bypass_in;
      s1_bypass_data_ff <= s1_bypass_data_in;
      s2_sample_ff      <= s2_sample_in;
      s2_old_ff         <= s2_old_in;
      s2_frame_end_ff   <= s2_frame_end_in;
      s2_in_range_ff    <= s2_in_range_in;
      s2_addr_ff        <= s2_addr_in;
      s2_blocks_ff      <= s2_blocks_in;
      s3_changed_ff     <= s3_changed_in;
      s3_blocks_ff      <= s3_blocks_in;
      rsp_payload_ff    <= rsp_payload_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_payload_ff;

endmodule
